// ===== rtl/bole_pkg.sv =====
// shared types and constants of the bounded ordered list engine
package bole_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TAIL_INS = 3'd0,
    CMD_HEAD_INS = 3'd1,
    CMD_SORT_INS = 3'd2,
    CMD_REM_VAL  = 3'd3,
    CMD_REM_HEAD = 3'd4,
    CMD_REM_TAIL = 3'd5,
    CMD_DUMP_FWD = 3'd6,
    CMD_DUMP_REV = 3'd7
  } cmd_e;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
    logic               item_valid;
    logic [ITEM_W-1:0]  item_value;
    logic               last;
  } res_t;

endpackage

// ===== rtl/bole_core.sv =====
// list sequencer with entry memory and shared compare unit
module bole_core #(
  parameter int unsigned DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  bole_pkg::cmd_e                  cmd_i,
  input  logic [bole_pkg::VALUE_W-1:0]    value_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output bole_pkg::res_t                  res_o
);
  import bole_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] ZERO = '0;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_e;

  state_e                state_q;
  cmd_e                  cmd_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         occ_q;
  logic [CW-1:0]         idx_q;
  logic [CW-1:0]         pos_q;
  logic                  fail_q;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  logic [CW-1:0] idx_inc, idx_dec, idx_inc2, pos_inc, occ_inc, occ_dec, rev_idx;
  logic          is_empty, is_full, is_ins, shift_up, lt, eq, hit;

  assign idx_inc  = idx_q + ONE;
  assign idx_inc2 = idx_q + CW'(2);
  assign idx_dec  = idx_q - ONE;
  assign pos_inc  = pos_q + ONE;
  assign occ_inc  = occ_q + ONE;
  assign occ_dec  = occ_q - ONE;
  assign rev_idx  = occ_dec - idx_q;
  assign is_empty = (occ_q == ZERO);
  assign is_full  = (occ_q == FULL);
  assign is_ins   = (cmd_q == CMD_TAIL_INS) || (cmd_q == CMD_HEAD_INS) ||
                    (cmd_q == CMD_SORT_INS);
  assign shift_up = (cmd_q == CMD_HEAD_INS) || (cmd_q == CMD_SORT_INS);

  // shared compare unit: order for sorted insert, match for removal
  assign lt  = $signed(rdata_q) < $signed(val_q);
  assign eq  = (rdata_q == val_q);
  assign hit = (cmd_q == CMD_SORT_INS) ? !lt : eq;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = occ_q[AW-1:0];
    mem_wdata = val_q;
    mem_re    = 1'b0;
    mem_raddr = pos_q[AW-1:0];
    unique case (state_q)
      S_DECODE: begin
        if (is_ins && !is_full && ((cmd_q == CMD_TAIL_INS) || is_empty)) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN_RD: begin
        mem_re = 1'b1;
      end
      S_SCAN_CMP: begin
        // no entry at least as large found: sorted value lands at the tail
        if ((cmd_q == CMD_SORT_INS) && !hit && (pos_inc == occ_q)) begin
          mem_we = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = shift_up ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
      end
      S_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = (cmd_q == CMD_DUMP_FWD) ? idx_q[AW-1:0] : rev_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_TAIL_INS;
      val_q   <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      fail_q  <= STATUS_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            val_q   <= DATA_WIDTH'(value_i);
            fail_q  <= STATUS_OK;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          pos_q <= '0;
          // head insert walks down from the tail, every other command starts its index at zero
          idx_q <= (cmd_q == CMD_HEAD_INS) ? occ_q : '0;
          unique case (cmd_q)
            CMD_TAIL_INS, CMD_HEAD_INS, CMD_SORT_INS: begin
              if (is_full) begin
                fail_q  <= STATUS_FAIL;
                state_q <= S_RESP;
              end else if ((cmd_q == CMD_TAIL_INS) || is_empty) begin
                occ_q   <= occ_inc;
                state_q <= S_RESP;
              end else if (cmd_q == CMD_HEAD_INS) begin
                state_q <= S_SHIFT_RD;
              end else begin
                state_q <= S_SCAN_RD;
              end
            end
            CMD_REM_VAL: begin
              if (is_empty) begin
                fail_q  <= STATUS_FAIL;
                state_q <= S_RESP;
              end else begin
                state_q <= S_SCAN_RD;
              end
            end
            CMD_REM_HEAD: begin
              if (is_empty) begin
                fail_q  <= STATUS_FAIL;
                state_q <= S_RESP;
              end else if (occ_q == ONE) begin
                occ_q   <= occ_dec;
                state_q <= S_RESP;
              end else begin
                state_q <= S_SHIFT_RD;
              end
            end
            CMD_REM_TAIL: begin
              if (is_empty) begin
                fail_q <= STATUS_FAIL;
              end else begin
                occ_q <= occ_dec;
              end
              state_q <= S_RESP;
            end
            CMD_DUMP_FWD, CMD_DUMP_REV: begin
              state_q <= is_empty ? S_RESP : S_DUMP_RD;
            end
          endcase
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (hit) begin
            if (cmd_q == CMD_SORT_INS) begin
              idx_q   <= occ_q;
              state_q <= S_SHIFT_RD;
            end else if (pos_inc == occ_q) begin
              occ_q   <= occ_dec;
              state_q <= S_RESP;
            end else begin
              idx_q   <= pos_q;
              state_q <= S_SHIFT_RD;
            end
          end else if (pos_inc == occ_q) begin
            if (cmd_q == CMD_SORT_INS) begin
              occ_q <= occ_inc;
            end else begin
              fail_q <= STATUS_FAIL;
            end
            state_q <= S_RESP;
          end else begin
            pos_q   <= pos_inc;
            state_q <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (shift_up) begin
            idx_q   <= idx_dec;
            state_q <= (idx_dec == pos_q) ? S_INS_WR : S_SHIFT_RD;
          end else if (idx_inc2 == occ_q) begin
            occ_q   <= occ_dec;
            state_q <= S_RESP;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_SHIFT_RD;
          end
        end
        S_INS_WR: begin
          occ_q   <= occ_inc;
          state_q <= S_RESP;
        end
        S_DUMP_RD: begin
          state_q <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (res_ready_i) begin
            idx_q   <= idx_inc;
            state_q <= (idx_inc == occ_q) ? S_IDLE : S_DUMP_RD;
          end
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP) || (state_q == S_DUMP_OUT);

  always_comb begin
    res_o             = '0;
    res_o.status      = fail_q;
    res_o.entry_count = COUNT_W'(occ_q);
    res_o.is_empty    = is_empty;
    res_o.is_full     = is_full;
    if (state_q == S_DUMP_OUT) begin
      res_o.item_valid = 1'b1;
      res_o.item_value = ITEM_W'(rdata_q);
      res_o.last       = (idx_inc == occ_q);
    end else begin
      res_o.last       = 1'b1;
    end
  end

endmodule

// ===== rtl/bounded_ordered_list_engine_top.sv =====
// top level of the bounded ordered list engine with stream ports
//
//  channel  | dir | tdata fields (low bit up)                      | tuser      | tlast
//  ---------+-----+------------------------------------------------+------------+------
//  s_axis   | in  | command[2:0], value[34:3], zero pad [39:35]    | -          | -
//  m_axis   | out | status[0], entry_count[5:1], is_empty[6],      | item_valid | last
//           |     | is_full[7], item_value[39:8]                   |            |
//
// one command at a time; s_axis_tready_o is low until its last beat is handed
// to the output register. each shift or scan step reads the entry memory into
// a read register and then compares or writes; a dump reads each entry before
// presenting it as a beat. reset empties the list; entry memory is not cleared.
// a stalled m_axis holds the beat in the output register and the sequencer
// waits
module bounded_ordered_list_engine_top #(
  parameter int unsigned DEPTH      = bole_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // command[2:0], value[34:3], pad
  input  logic [bole_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[0], entry_count[5:1], is_empty[6], is_full[7], item_value[39:8]
  output logic [bole_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // item_valid[0]
  output logic [0:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import bole_pkg::*;

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_q;

  // sequencer, entry memory and shared comparator
  bole_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (cmd_e'(s_axis_tdata_i[CMD_W-1:0])),
    .value_i     (s_axis_tdata_i[CMD_W +: VALUE_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: takes a new beat when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.item_value, out_q.is_full, out_q.is_empty,
                            out_q.entry_count, out_q.status};
  assign m_axis_tuser_o  = out_q.item_valid;
  assign m_axis_tlast_o  = out_q.last;

endmodule
